// ===== sv/mpu_pkg.sv =====
// Shared types and constants for the masked pixel unpacker.
// Used by mpu_chan and masked_pixel_unpack_rgba8; depends on nothing.
package mpu_pkg;

  // Field widths
  localparam int PixW     = 32;
  localparam int ShW      = 5;
  localparam int ChW      = 8;
  localparam int NumChan  = 4;
  localparam int CfgIdxW  = 3;

  // Remainder width: the scaled field value times 255 fits in PixW + ChW bits
  localparam int RemW     = PixW + ChW;

  // One quotient bit per division stage; the quotient never exceeds 255
  localparam int DivSteps  = ChW;
  // Input register, field extract, numerator, then the division stages
  localparam int NumStages = DivSteps + 3;

  // Output full scale
  localparam logic [ChW-1:0] FullScale = 8'hFF;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_RED_MASK    = 3'd0,
    REG_RED_SHIFT   = 3'd1,
    REG_GREEN_MASK  = 3'd2,
    REG_GREEN_SHIFT = 3'd3,
    REG_BLUE_MASK   = 3'd4,
    REG_BLUE_SHIFT  = 3'd5,
    REG_ALPHA_MASK  = 3'd6,
    REG_ALPHA_SHIFT = 3'd7
  } cfg_reg_e;

  // Reset values select R5G6B5 with no alpha
  localparam logic [PixW-1:0] RstRedMask    = 32'h0000_F800;
  localparam logic [ShW-1:0]  RstRedShift   = 5'd11;
  localparam logic [PixW-1:0] RstGreenMask  = 32'h0000_07E0;
  localparam logic [ShW-1:0]  RstGreenShift = 5'd5;
  localparam logic [PixW-1:0] RstBlueMask   = 32'h0000_001F;
  localparam logic [ShW-1:0]  RstBlueShift  = 5'd0;
  localparam logic [PixW-1:0] RstAlphaMask  = 32'h0000_0000;
  localparam logic [ShW-1:0]  RstAlphaShift = 5'd0;

  // Settings of one channel as seen by its datapath
  typedef struct packed {
    logic [PixW-1:0] mask;
    logic [ShW-1:0]  shift;
    logic            opaque;   // force full scale (alpha with a zero mask)
  } chan_cfg_t;

endpackage

// ===== sv/mpu_chan.sv =====
// Datapath of one channel: field extract, multiply by 255 and an eight-stage
// restoring divider by the field's full-scale value. Depends on mpu_pkg.
module mpu_chan (
  input  logic                                 clk_i,
  input  logic [mpu_pkg::NumStages-1:0]        load_i,
  input  logic [mpu_pkg::PixW-1:0]             pixel_i,
  input  mpu_pkg::chan_cfg_t                   cfg_i,
  output logic [mpu_pkg::ChW-1:0]              chan_o
);

  localparam int PixW     = mpu_pkg::PixW;
  localparam int ChW      = mpu_pkg::ChW;
  localparam int RemW     = mpu_pkg::RemW;
  localparam int DivSteps = mpu_pkg::DivSteps;

  // Stage 0: input pixel
  logic [PixW-1:0] pix_q;

  // Stage 1: extracted field and full-scale value
  logic [PixW-1:0] val_q, full_q;
  logic            kill_q, opaque_q;
  logic [PixW-1:0] full_d;

  // Division stages
  logic [RemW-1:0] rem_q [DivSteps];
  logic [PixW-1:0] div_q [DivSteps];
  logic [ChW-1:0]  quo_q [DivSteps];

  // Capture the pixel
  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      pix_q <= pixel_i;
    end
  end

  // Mask and shift the field down; a zero full scale gives output zero
  assign full_d = cfg_i.mask >> cfg_i.shift;

  always_ff @(posedge clk_i) begin
    if (load_i[1]) begin
      val_q    <= (pix_q & cfg_i.mask) >> cfg_i.shift;
      full_q   <= full_d;
      kill_q   <= (full_d == '0);
      opaque_q <= cfg_i.opaque;
    end
  end

  // Numerator value*255 as (value << 8) - value. The special cases divide
  // a fixed numerator by one so that the divider yields 255 or 0.
  always_ff @(posedge clk_i) begin
    if (load_i[2]) begin
      if (opaque_q) begin
        rem_q[0] <= RemW'(mpu_pkg::FullScale);
        div_q[0] <= PixW'(1);
      end else if (kill_q) begin
        rem_q[0] <= '0;
        div_q[0] <= PixW'(1);
      end else begin
        rem_q[0] <= {val_q, {ChW{1'b0}}} - {{ChW{1'b0}}, val_q};
        div_q[0] <= full_q;
      end
    end
  end

  // Restoring division, one quotient bit per stage, most significant first
  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    localparam int Bit = DivSteps - 1 - j;
    logic [RemW-1:0] trial;
    logic            ge;
    logic [ChW-1:0]  quo_in, quo_d;

    assign trial = {{ChW{1'b0}}, div_q[j]} << Bit;
    assign ge    = (rem_q[j] >= trial);

    if (j == 0) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      quo_d      = quo_in;
      quo_d[Bit] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (load_i[3+j]) begin
        quo_q[j] <= quo_d;
      end
    end

    if (j < DivSteps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (load_i[3+j]) begin
          rem_q[j+1] <= ge ? (rem_q[j] - trial) : rem_q[j];
          div_q[j+1] <= div_q[j];
        end
      end
    end
  end

  assign chan_o = quo_q[DivSteps-1];

endmodule

// ===== sv/masked_pixel_unpack_rgba8.sv =====
// Top level of the masked pixel unpacker: configuration registers, stage
// valid tracking and four channel datapaths. Depends on mpu_pkg and mpu_chan.
//
// Takes one packed pixel of up to 32 bits per beat and returns one RGBA8888
// beat. Each channel is masked, shifted down and scaled to 0..255 as
// floor(value*255/full_scale). Throughput is one pixel per clock while the
// output is not stalled. The pipeline is made up of the input register, the
// field extract stage, the numerator stage and the eight stages of the
// restoring divider, one quotient bit each. Every stage holds its beat while
// downstream is stalled, and empty stages fill up, so a stalled output still
// lets pixels enter until the pipeline is full. Configuration writes are
// always accepted and must only be made while no pixel is in flight.
module masked_pixel_unpack_rgba8 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Pixel input: tdata = packed_pixel[31:0]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,
  // RGBA output: tdata = red_out[7:0], green_out[15:8], blue_out[23:16],
  // alpha_out[31:24]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mpu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  localparam int NumStages = mpu_pkg::NumStages;
  localparam int PixW      = mpu_pkg::PixW;
  localparam int ShW       = mpu_pkg::ShW;
  localparam int ChW       = mpu_pkg::ChW;
  localparam int NumChan   = mpu_pkg::NumChan;

  // Configuration registers
  logic [PixW-1:0] red_mask_q, green_mask_q, blue_mask_q, alpha_mask_q;
  logic [ShW-1:0]  red_shift_q, green_shift_q, blue_shift_q, alpha_shift_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_mask_q    <= mpu_pkg::RstRedMask;
      red_shift_q   <= mpu_pkg::RstRedShift;
      green_mask_q  <= mpu_pkg::RstGreenMask;
      green_shift_q <= mpu_pkg::RstGreenShift;
      blue_mask_q   <= mpu_pkg::RstBlueMask;
      blue_shift_q  <= mpu_pkg::RstBlueShift;
      alpha_mask_q  <= mpu_pkg::RstAlphaMask;
      alpha_shift_q <= mpu_pkg::RstAlphaShift;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mpu_pkg::cfg_reg_e'(cfg_index_i))
        mpu_pkg::REG_RED_MASK:    red_mask_q    <= cfg_data_i;
        mpu_pkg::REG_RED_SHIFT:   red_shift_q   <= cfg_data_i[ShW-1:0];
        mpu_pkg::REG_GREEN_MASK:  green_mask_q  <= cfg_data_i;
        mpu_pkg::REG_GREEN_SHIFT: green_shift_q <= cfg_data_i[ShW-1:0];
        mpu_pkg::REG_BLUE_MASK:   blue_mask_q   <= cfg_data_i;
        mpu_pkg::REG_BLUE_SHIFT:  blue_shift_q  <= cfg_data_i[ShW-1:0];
        mpu_pkg::REG_ALPHA_MASK:  alpha_mask_q  <= cfg_data_i;
        mpu_pkg::REG_ALPHA_SHIFT: alpha_shift_q <= cfg_data_i[ShW-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel settings; a zero alpha mask means fully opaque
  mpu_pkg::chan_cfg_t chan_cfg [NumChan];

  assign chan_cfg[0] = '{mask: red_mask_q,   shift: red_shift_q,   opaque: 1'b0};
  assign chan_cfg[1] = '{mask: green_mask_q, shift: green_shift_q, opaque: 1'b0};
  assign chan_cfg[2] = '{mask: blue_mask_q,  shift: blue_shift_q,  opaque: 1'b0};
  assign chan_cfg[3] = '{mask: alpha_mask_q, shift: alpha_shift_q,
                         opaque: (alpha_mask_q == '0)};

  // Stage valid bits; a stage loads when it is empty or its successor moves
  logic [NumStages-1:0] vld_q, vld_d, load;

  always_comb begin
    load[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (load[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (load[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = load[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  // Channel datapaths
  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    mpu_chan u_chan (
      .clk_i   (clk_i),
      .load_i  (load),
      .pixel_i (s_axis_tdata),
      .cfg_i   (chan_cfg[c]),
      .chan_o  (m_axis_tdata[c*ChW +: ChW])
    );
  end

  // A stage holding a beat that cannot move keeps it
  for (genvar k = 0; k < NumStages; k++) begin : g_hold_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      vld_q[k] && !load[k] |=> vld_q[k])
      else $error("pipeline stage dropped a stalled beat");
  end

  // An accepted pixel occupies the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted pixel missing from first stage");

  // Beats in flight change only by accepts and deliveries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(vld_q) == $past($countones(vld_q))
             + int'($past(s_axis_tvalid && s_axis_tready))
             - int'($past(m_axis_tvalid && m_axis_tready)))
    else $error("beat count in pipeline inconsistent");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for masked_pixel_unpack_rgba8: drives pixel beats through
// a range of channel formats and checks every RGBA beat against a local predictor.
// Depends on mpu_pkg and the masked_pixel_unpack_rgba8 RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mpu_pkg::*;

  // Channel slots in the local copy of the format registers
  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;
  localparam int ChAlpha = 3;

  localparam int LongHold   = 200;
  localparam int IdleLimit  = 2000;
  localparam int RandPhases = 6;
  localparam int PhaseItems = 75;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_e;

  // One output beat, red in the lowest byte as on m_axis_tdata
  typedef struct packed {
    logic [ChW-1:0] alpha;
    logic [ChW-1:0] blue;
    logic [ChW-1:0] green;
    logic [ChW-1:0] red;
  } rgba_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [31:0]     s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;
  logic            cfg_valid_i   = 1'b0;
  logic            cfg_ready_o;
  cfg_reg_e        cfg_index     = REG_RED_MASK;
  logic [31:0]     cfg_data      = '0;

  // Local copy of the format registers, updated on each accepted write
  logic [PixW-1:0] fmt_mask  [NumChan] = '{RstRedMask, RstGreenMask, RstBlueMask, RstAlphaMask};
  logic [ShW-1:0]  fmt_shift [NumChan] = '{RstRedShift, RstGreenShift, RstBlueShift,
                                           RstAlphaShift};

  logic [31:0] pixel_q [$];
  rgba_t       rgba_expected [$];

  // Stimulus controls, written only by the sequencing initial block
  rx_style_e rx_style    = RX_ALWAYS;
  logic      tx_bursty   = 1'b0;
  logic      hold_req    = 1'b0;

  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  logic        hold_seen   = 1'b0;
  int unsigned hold_left   = 0;
  logic [15:0] rx_pattern  = 16'b1110_1101_1011_0111;
  int unsigned idle_cycles = 0;
  int unsigned mismatches  = 0;

  masked_pixel_unpack_rgba8 dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #1 clk = ~clk;

  // Scale one masked field to 0..255; a field with no bits left after the shift gives 0.
  function automatic logic [ChW-1:0] scale_field(input logic [PixW-1:0] pix,
                                                 input logic [PixW-1:0] mask,
                                                 input logic [ShW-1:0] sh);
    logic [PixW-1:0]     full;
    logic [PixW-1:0]     fval;
    logic [PixW+ChW-1:0] num;
    full = mask >> sh;
    fval = (pix & mask) >> sh;
    if (full == '0) return '0;
    num = {{ChW{1'b0}}, fval} * 40'd255;
    return ChW'(num / {{ChW{1'b0}}, full});
  endfunction

  // Expected RGBA beat for one pixel under the current format.
  function automatic rgba_t unpack_pixel(input logic [PixW-1:0] pix);
    rgba_t px;
    px.red   = scale_field(pix, fmt_mask[ChRed], fmt_shift[ChRed]);
    px.green = scale_field(pix, fmt_mask[ChGreen], fmt_shift[ChGreen]);
    px.blue  = scale_field(pix, fmt_mask[ChBlue], fmt_shift[ChBlue]);
    if (fmt_mask[ChAlpha] == '0) begin
      px.alpha = FullScale;
    end else begin
      px.alpha = scale_field(pix, fmt_mask[ChAlpha], fmt_shift[ChAlpha]);
    end
    return px;
  endfunction

  // Random pixel, biased towards 16-bit pixels and saturated or cleared fields.
  function automatic logic [PixW-1:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return {16'd0, 16'($urandom())};
      1: return $urandom() | fmt_mask[$urandom_range(0, NumChan - 1)];
      2: return $urandom() & ~fmt_mask[$urandom_range(0, NumChan - 1)];
      default: return $urandom();
    endcase
  endfunction

  // Shift write data carries random junk above the five register bits.
  function automatic logic [31:0] pad_shift(input logic [ShW-1:0] sh);
    return {27'($urandom()), sh};
  endfunction

  // Sender: bursts of random length, separated by random gaps when tx_bursty is set; holds a beat until taken.
  always @(posedge clk) begin : pixel_driver
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready) begin
        rgba_expected.push_back(unpack_pixel(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= (tx_bursty && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall style per phase, plus a long hold-off on request.
  always @(posedge clk) begin : rgba_receiver
    rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
    if (hold_req != hold_seen) begin
      hold_seen     <= hold_req;
      hold_left     <= LongHold;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: m_axis_tready <= rx_pattern[0];
        default:    m_axis_tready <= 1'b1;
      endcase
    end
  end

  task automatic check_chan(input string name, input logic [ChW-1:0] want,
                            input logic [ChW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each accepted RGBA beat with the oldest prediction.
  always @(posedge clk) begin : rgba_monitor
    rgba_t got;
    rgba_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (rgba_expected.size() == 0) begin
        $display("%0t: unexpected RGBA beat, expected none, actual %08h", $time, got);
        mismatches++;
      end else begin
        want = rgba_expected.pop_front();
        check_chan("red", want.red, got.red);
        check_chan("green", want.green, got.green);
        check_chan("blue", want.blue, got.blue);
        check_chan("alpha", want.alpha, got.alpha);
      end
    end
  end

  // Watchdog on cycles in which no channel moves a beat.
  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no beat for %0d cycles", $time, idle_cycles);
      $display("masked_pixel_unpack_rgba8 verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Called at a rising edge; leaves the write valid high for a following write.
  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index   <= idx;
    cfg_data    <= data;
    do @(posedge clk); while (!cfg_ready_o);
    case (idx)
      REG_RED_MASK:    fmt_mask[ChRed]    = data;
      REG_RED_SHIFT:   fmt_shift[ChRed]   = data[ShW-1:0];
      REG_GREEN_MASK:  fmt_mask[ChGreen]  = data;
      REG_GREEN_SHIFT: fmt_shift[ChGreen] = data[ShW-1:0];
      REG_BLUE_MASK:   fmt_mask[ChBlue]   = data;
      REG_BLUE_SHIFT:  fmt_shift[ChBlue]  = data[ShW-1:0];
      REG_ALPHA_MASK:  fmt_mask[ChAlpha]  = data;
      REG_ALPHA_SHIFT: fmt_shift[ChAlpha] = data[ShW-1:0];
      default: ;
    endcase
  endtask

  task automatic program_format(input logic [31:0] rm, input logic [ShW-1:0] rs,
                                input logic [31:0] gm, input logic [ShW-1:0] gs,
                                input logic [31:0] bm, input logic [ShW-1:0] bs,
                                input logic [31:0] am, input logic [ShW-1:0] as);
    cfg_write(REG_RED_MASK, rm);
    cfg_write(REG_RED_SHIFT, pad_shift(rs));
    cfg_write(REG_GREEN_MASK, gm);
    cfg_write(REG_GREEN_SHIFT, pad_shift(gs));
    cfg_write(REG_BLUE_MASK, bm);
    cfg_write(REG_BLUE_SHIFT, pad_shift(bs));
    cfg_write(REG_ALPHA_MASK, am);
    cfg_write(REG_ALPHA_SHIFT, pad_shift(as));
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every pixel has gone in and every RGBA beat has come out; ends on a rising edge.
  task automatic drain();
    do @(negedge clk); while (pixel_q.size() != 0 || s_axis_tvalid || rgba_expected.size() != 0);
    @(posedge clk);
  endtask

  // Mostly a contiguous field with its shift at the low bit; sometimes a broken one.
  task automatic rand_field(output logic [31:0] m, output logic [ShW-1:0] s);
    int unsigned w;
    int unsigned lsb;
    logic [63:0] ones;
    w    = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 10);
    lsb  = $urandom_range(0, 32 - w);
    ones = (64'd1 << w) - 64'd1;
    m    = 32'(ones << lsb);
    s    = ShW'(lsb);
    case ($urandom_range(0, 11))
      0: m = '0;
      1: m = $urandom();
      2: s = ShW'($urandom());
      3: m = '1;
      default: ;
    endcase
  endtask

  initial begin : sequencer
    logic [31:0]    rm, gm, bm, am;
    logic [ShW-1:0] rs, gs, bs, as;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset format, R5G6B5 without alpha; upper pixel bits must be ignored
    @(negedge clk);
    pixel_q = '{32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_8410, 32'h0000_7BEF};
    drain();

    // ARGB8888
    program_format(32'h00FF_0000, 5'd16, 32'h0000_FF00, 5'd8,
                   32'h0000_00FF, 5'd0, 32'hFF00_0000, 5'd24);
    @(negedge clk);
    pixel_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h80FF_7F01};
    drain();

    // Zero red mask, green mask shifted out, non-contiguous blue, full-width alpha
    program_format(32'h0000_0000, 5'd7, 32'h0000_000F, 5'd8,
                   32'hA5A5_A5A5, 5'd0, 32'hFFFF_FFFF, 5'd0);
    @(negedge clk);
    pixel_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                32'h0000_0001, 32'hFFFF_FFFE};
    drain();

    // One-bit red at the top, split green, one-bit blue, zero alpha mask with a large shift
    program_format(32'hFFFF_FFFF, 5'd31, 32'h8000_0001, 5'd0,
                   32'h0000_0001, 5'd0, 32'h0000_0000, 5'd31);
    @(negedge clk);
    pixel_q = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    drain();

    // A1R5G5B5
    program_format(32'h0000_7C00, 5'd10, 32'h0000_03E0, 5'd5,
                   32'h0000_001F, 5'd0, 32'h0000_8000, 5'd15);
    @(negedge clk);
    pixel_q = '{32'h0000_8000, 32'h0000_7FFF, 32'h0000_AAAA};
    drain();

    // R4G4B4A4 with the alpha field shifted out entirely
    program_format(32'h0000_F000, 5'd12, 32'h0000_0F00, 5'd8,
                   32'h0000_00F0, 5'd4, 32'h0000_000F, 5'd16);
    @(negedge clk);
    pixel_q = '{32'h0000_1234, 32'h0000_FFFF};
    drain();

    // Random formats and pixels
    for (int p = 0; p < RandPhases; p++) begin
      rand_field(rm, rs);
      rand_field(gm, gs);
      rand_field(bm, bs);
      rand_field(am, as);
      case (p)
        0: begin
          rx_style  <= RX_ALWAYS;
          tx_bursty <= 1'b0;
        end
        1: begin
          rx_style  <= RX_RANDOM;
          tx_bursty <= 1'b0;
        end
        2: begin
          rx_style  <= RX_PATTERN;
          tx_bursty <= 1'b1;
        end
        default: begin
          rx_style  <= rx_style_e'($urandom_range(0, 2));
          tx_bursty <= 1'($urandom());
        end
      endcase
      program_format(rm, rs, gm, gs, bm, bs, am, as);
      @(negedge clk);
      for (int i = 0; i < PhaseItems / 2; i++) pixel_q.push_back(pick_pixel());
      // Stall the output long enough for the pipeline to fill and push back
      if (p == 1) begin
        @(posedge clk);
        hold_req <= ~hold_req;
      end
      // Let everything drain mid-phase before sending the rest
      if (p == 2) begin
        drain();
        @(negedge clk);
      end
      for (int i = PhaseItems / 2; i < PhaseItems; i++) pixel_q.push_back(pick_pixel());
      drain();
    end

    repeat (NumStages + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("masked_pixel_unpack_rgba8 verification clean");
    end else begin
      $display("masked_pixel_unpack_rgba8 verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mpu_pkg.sv
sv/mpu_chan.sv
sv/masked_pixel_unpack_rgba8.sv
verif/tb_top.sv
